// ===== src/ffp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants for the feedback frame parser: frame bytes,
// status codes, register indexes and the parser phase type.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int BUF_BYTES = 64;
  // longest data length accepted in a frame
  localparam int MAX_LEN   = BUF_BYTES - 4;
  // position and length counters hold 0..MAX_LEN
  localparam int POS_W     = $clog2(MAX_LEN + 1);

  localparam logic [7:0] HDR_BYTE   = 8'hAA;
  localparam logic [7:0] FN_MOTOR   = 8'h01;
  localparam logic [7:0] FN_SENSOR  = 8'h03;
  localparam int         UPDATE_LEN = 7;
  localparam int         CAP_DEPTH  = 7;
  localparam int         CAP_IDX_W  = $clog2(CAP_DEPTH);

  localparam logic [1:0] STAT_MOTOR  = 2'd0;
  localparam logic [1:0] STAT_SENSOR = 2'd1;
  localparam logic [1:0] STAT_GOOD   = 2'd2;
  localparam logic [1:0] STAT_BAD    = 2'd3;

  localparam int         CFG_IDX_W       = 1;
  localparam int         CFG_DATA_W      = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 1'd1;

  localparam logic [7:0] MOTOR_COUNT_RST  = 8'd3;
  localparam logic [7:0] SENSOR_COUNT_RST = 8'd4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_FUNC,
    PH_LEN,
    PH_DATA
  } phase_t;

endpackage

// ===== src/feedback_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_frame_parser_top
// Byte-serial parser for length-prefixed feedback frames with an additive
// checksum; reports one result per completed frame.
//
//   channel  | ports                         | direction | handshake
//   ---------+-------------------------------+-----------+-------------
//   in_      | in_rx_byte                    | in        | valid/ready
//   out_     | status, func_code, frame_len, | out       | valid/ready
//            | entity_id, value_a/b/c        |           |
//   cfg_     | cfg_we, cfg_index, cfg_wdata  | in        | write enable
//
// One byte per cycle sustained. A byte sits in the input register, is parsed
// there, and a result lands in the output register: out_valid rises once the
// checksum byte is parsed from the input register. Synchronous active-low
// reset returns the parser to header hunt and restores the count registers.
// A stalled result blocks only the byte that completes the next frame; other
// bytes keep flowing.
// ----------------------------------------------------------------------------
module feedback_frame_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_func_code,
  output logic [5:0]                      out_frame_len,
  output logic [7:0]                      out_entity_id,
  output logic signed [15:0]              out_value_a,
  output logic signed [15:0]              out_value_b,
  output logic signed [15:0]              out_value_c,
  input  logic                            cfg_we,
  input  logic [ffp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ffp_pkg::*;

  // configuration
  logic [7:0] motor_count_r, sensor_count_r;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       cap_r [CAP_DEPTH];
  logic             cap_we;

  // output register
  logic              out_vld_r;
  logic [1:0]        status_r, status_nxt;
  logic [7:0]        func_out_r;
  logic [5:0]        len_out_r;
  logic [7:0]        id_out_r;
  logic signed [15:0] val_a_r, val_b_r, val_c_r, val_a_nxt, val_b_nxt, val_c_nxt;

  logic produce, out_free, advance;
  logic id_ok_motor, id_ok_sensor;

  assign produce  = in_vld_r && (phase_r == PH_DATA) && (pos_r == len_r);
  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && (out_free || !produce);
  assign in_ready = !in_vld_r || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_count_r  <= MOTOR_COUNT_RST;
      sensor_count_r <= SENSOR_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOTOR_COUNT:  motor_count_r  <= cfg_wdata;
        REG_SENSOR_COUNT: sensor_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: hold until parsed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  assign id_ok_motor  = (cap_r[0] != 8'd0) && (cap_r[0] <= motor_count_r);
  assign id_ok_sensor = (cap_r[0] != 8'd0) && (cap_r[0] <= sensor_count_r);

  always_comb begin
    phase_nxt  = phase_r;
    func_nxt   = func_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cap_we     = 1'b0;
    status_nxt = STAT_GOOD;
    val_a_nxt  = '0;
    val_b_nxt  = '0;
    val_c_nxt  = '0;

    case (phase_r)
      PH_HUNT: begin
        if (in_byte_r == HDR_BYTE) begin
          sum_nxt   = in_byte_r;
          pos_nxt   = '0;
          phase_nxt = PH_FUNC;
        end
      end
      PH_FUNC: begin
        func_nxt  = in_byte_r;
        sum_nxt   = sum_r + in_byte_r;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (in_byte_r == 8'd0 || in_byte_r > 8'(MAX_LEN)) begin
          // drop the frame and hunt again
          phase_nxt = PH_HUNT;
          func_nxt  = '0;
          len_nxt   = '0;
          pos_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          len_nxt   = POS_W'(in_byte_r);
          sum_nxt   = sum_r + in_byte_r;
          pos_nxt   = '0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (pos_r != len_r) begin
          cap_we  = (pos_r < POS_W'(CAP_DEPTH));
          pos_nxt = pos_r + POS_W'(1);
          sum_nxt = sum_r + in_byte_r;
        end else begin
          if (sum_r != in_byte_r) begin
            status_nxt = STAT_BAD;
          end else if (func_r == FN_MOTOR && len_r == POS_W'(UPDATE_LEN) && id_ok_motor) begin
            status_nxt = STAT_MOTOR;
          end else if (func_r == FN_SENSOR && len_r == POS_W'(UPDATE_LEN) &&
                       id_ok_sensor) begin
            status_nxt = STAT_SENSOR;
          end else begin
            status_nxt = STAT_GOOD;
          end
          if (status_nxt == STAT_MOTOR || status_nxt == STAT_SENSOR) begin
            val_a_nxt = $signed({cap_r[1], cap_r[2]});
            val_b_nxt = $signed({cap_r[3], cap_r[4]});
            val_c_nxt = $signed({cap_r[5], cap_r[6]});
          end
          phase_nxt = PH_HUNT;
          func_nxt  = '0;
          len_nxt   = '0;
          pos_nxt   = '0;
          sum_nxt   = '0;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // parser state advances once per parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      func_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // capture store for the first data bytes of a frame
  always_ff @(posedge clk) begin
    if (advance && cap_we) begin
      cap_r[pos_r[CAP_IDX_W-1:0]] <= in_byte_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      status_r   <= status_nxt;
      func_out_r <= func_r;
      len_out_r  <= 6'(len_r);
      id_out_r   <= cap_r[0];
      val_a_r    <= val_a_nxt;
      val_b_r    <= val_b_nxt;
      val_c_r    <= val_c_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = status_r;
  assign out_func_code = func_out_r;
  assign out_frame_len = len_out_r;
  assign out_entity_id = id_out_r;
  assign out_value_a   = val_a_r;
  assign out_value_b   = val_b_r;
  assign out_value_c   = val_c_r;

endmodule

// ===== src/ffp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_checker
// Port-level checks for the feedback frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ffp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_status,
  input logic [7:0]                      out_func_code,
  input logic [5:0]                      out_frame_len,
  input logic [7:0]                      out_entity_id,
  input logic signed [15:0]              out_value_a,
  input logic signed [15:0]              out_value_b,
  input logic signed [15:0]              out_value_c
);
  import ffp_pkg::*;

  // a stalled result holds its status, entity id and value_a
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_entity_id) && $stable(out_value_a))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // values are zero unless the result is an update
  a_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_GOOD || out_status == STAT_BAD) |->
    out_value_a == 16'sd0 && out_value_b == 16'sd0 && out_value_c == 16'sd0)
    else $error("non-update result carries values");

  // updates only come from well-formed update frames
  a_update_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_MOTOR || out_status == STAT_SENSOR) |->
    out_frame_len == 6'(UPDATE_LEN) && out_entity_id != 8'd0 &&
    ((out_status == STAT_MOTOR && out_func_code == FN_MOTOR) ||
     (out_status == STAT_SENSOR && out_func_code == FN_SENSOR)))
    else $error("update from wrong frame");

endmodule

bind feedback_frame_parser_top ffp_checker u_ffp_checker (.*);
